// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the murmur hash modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is asserted
`define MMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every rising edge, including cycles in reset
`define MMH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/mmh_pkg.sv =====
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types, constants and the microcode program of the murmur hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

  // mixing constants
  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [4:0]  MIX_SHIFT  = 5'd24;
  localparam logic [31:0] SEED_RESET = 32'hABC84D09;

  // finalization shift amounts
  localparam logic [4:0] FIN_SH1 = 5'd18;
  localparam logic [4:0] FIN_SH2 = 5'd22;
  localparam logic [4:0] FIN_SH3 = 5'd17;
  localparam logic [4:0] FIN_SH4 = 5'd19;

  // valid byte counts
  localparam logic [2:0] NV_ONE   = 3'd1;
  localparam logic [2:0] NV_TWO   = 3'd2;
  localparam logic [2:0] NV_FULL  = 3'd4;

  // microprogram addresses
  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_MIX1 = 4'd1;
  localparam step_t STEP_MIX2 = 4'd2;
  localparam step_t STEP_LANE = 4'd3;
  localparam step_t STEP_TAIL = 4'd4;
  localparam step_t STEP_FIN1 = 4'd5;
  localparam step_t STEP_FIN2 = 4'd6;
  localparam step_t STEP_FIN3 = 4'd7;
  localparam step_t STEP_FIN4 = 4'd8;
  localparam step_t STEP_EMIT = 4'd9;

  // multiplier operand source
  typedef enum logic [2:0] {
    SRC_WORD,
    SRC_KMIX,
    SRC_LANE,
    SRC_TAIL,
    SRC_FIN_A,
    SRC_FIN_B
  } mul_src_t;

  // product destination
  typedef enum logic [2:0] {
    DST_NONE,
    DST_K,
    DST_A,
    DST_B,
    DST_LANE
  } mul_dst_t;

  // sequencing condition
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_DISPATCH,
    JMP_LAST,
    JMP_WAIT_OUT
  } jump_t;

  // one control word of the program
  typedef struct packed {
    logic     init;
    mul_src_t src;
    mul_dst_t dst;
    logic     xor_k;
    logic     flip;
    logic     emit;
    logic [4:0] shamt;
    jump_t    jmp;
    step_t    target;
  } ctrl_word_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic full;
    logic partial;
    logic last;
    logic out_free;
  } dp_stat_t;

  // control word with its execute enable
  typedef struct packed {
    ctrl_word_t word;
    logic       step_en;
  } dp_ctrl_t;

  function automatic ctrl_word_t cw(logic init, mul_src_t src, mul_dst_t dst,
                                    logic xor_k, logic flip, logic emit,
                                    logic [4:0] shamt, jump_t jmp, step_t target);
    ctrl_word_t w;
    w.init   = init;
    w.src    = src;
    w.dst    = dst;
    w.xor_k  = xor_k;
    w.flip   = flip;
    w.emit   = emit;
    w.shamt  = shamt;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // microcode store
  function automatic ctrl_word_t ucode_rom(step_t addr);
    ctrl_word_t w;
    case (addr)
      STEP_IDLE: w = cw(1'b0, SRC_WORD,  DST_NONE, 1'b0, 1'b0, 1'b0, 5'd0,
                        JMP_WAIT_IN, STEP_IDLE);
      STEP_MIX1: w = cw(1'b1, SRC_WORD,  DST_K,    1'b0, 1'b0, 1'b0, 5'd0,
                        JMP_DISPATCH, STEP_TAIL);
      STEP_MIX2: w = cw(1'b0, SRC_KMIX,  DST_K,    1'b0, 1'b0, 1'b0, MIX_SHIFT,
                        JMP_NEXT, STEP_IDLE);
      STEP_LANE: w = cw(1'b0, SRC_LANE,  DST_LANE, 1'b1, 1'b1, 1'b0, 5'd0,
                        JMP_LAST, STEP_FIN1);
      STEP_TAIL: w = cw(1'b0, SRC_TAIL,  DST_B,    1'b0, 1'b0, 1'b0, 5'd0,
                        JMP_LAST, STEP_FIN1);
      STEP_FIN1: w = cw(1'b0, SRC_FIN_A, DST_A,    1'b0, 1'b0, 1'b0, FIN_SH1,
                        JMP_NEXT, STEP_IDLE);
      STEP_FIN2: w = cw(1'b0, SRC_FIN_B, DST_B,    1'b0, 1'b0, 1'b0, FIN_SH2,
                        JMP_NEXT, STEP_IDLE);
      STEP_FIN3: w = cw(1'b0, SRC_FIN_A, DST_A,    1'b0, 1'b0, 1'b0, FIN_SH3,
                        JMP_NEXT, STEP_IDLE);
      STEP_FIN4: w = cw(1'b0, SRC_FIN_B, DST_B,    1'b0, 1'b0, 1'b0, FIN_SH4,
                        JMP_NEXT, STEP_IDLE);
      STEP_EMIT: w = cw(1'b0, SRC_WORD,  DST_NONE, 1'b0, 1'b0, 1'b1, 5'd0,
                        JMP_WAIT_OUT, STEP_IDLE);
      default:   w = cw(1'b0, SRC_WORD,  DST_NONE, 1'b0, 1'b0, 1'b0, 5'd0,
                        JMP_NEXT, STEP_IDLE);
    endcase
    return w;
  endfunction

  // byte mask for a partial tail word
  function automatic logic [31:0] tail_mask(logic [2:0] nvalid);
    logic [31:0] m;
    if (nvalid == NV_ONE) begin
      m = 32'h0000_00FF;
    end else if (nvalid == NV_TWO) begin
      m = 32'h0000_FFFF;
    end else begin
      m = 32'h00FF_FFFF;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/mmh_sequencer.sv =====
// ----------------------------------------------------------------------------
// mmh_sequencer
// Step counter and microcode store; issues one control word per cycle, stalling at emit while output is occupied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mmh_sequencer
  import mmh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_ctrl_t      ctrl
);

  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t word;

  // control store lookup
  assign word = ucode_rom(step_r);

  // input is taken only at the top of the program
  assign in_ready = (step_r == STEP_IDLE);

  // hold the emit step while the output register is occupied
  always_comb begin
    ctrl.word    = word;
    ctrl.step_en = !((word.jmp == JMP_WAIT_OUT) && !stat.out_free);
  end

  // next step address
  always_comb begin
    case (word.jmp)
      JMP_NEXT:    step_nxt = step_r + 4'd1;
      JMP_WAIT_IN: step_nxt = in_valid ? step_r + 4'd1 : step_r;
      JMP_DISPATCH: begin
        if (stat.full) begin
          step_nxt = step_r + 4'd1;
        end else if (stat.partial) begin
          step_nxt = word.target;
        end else if (stat.last) begin
          step_nxt = STEP_FIN1;
        end else begin
          step_nxt = STEP_IDLE;
        end
      end
      JMP_LAST:     step_nxt = stat.last ? word.target : STEP_IDLE;
      JMP_WAIT_OUT: step_nxt = stat.out_free ? STEP_IDLE : step_r;
      default:      step_nxt = STEP_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // checks
  `MMH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> step_r == STEP_IDLE,
    "sequencer not at idle after reset")
  `MMH_ASSERT(a_step_range, clk, rst_n, step_r <= STEP_EMIT,
    "step counter outside program")
  `MMH_ASSERT(a_accept_mix, clk, rst_n, (in_valid && in_ready) |=> step_r == STEP_MIX1,
    "accepted transaction did not start the mix")

endmodule

`default_nettype wire

// ===== design/mmh_datapath.sv =====
// ----------------------------------------------------------------------------
// mmh_datapath
// Lanes, mix register, shared 32-bit multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mmh_datapath
  import mmh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr,
  input  wire logic [31:0] cfg_seed,
  input  wire logic        load,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic [31:0] in_key_length,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  input  wire dp_ctrl_t    ctrl,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_hash_value
);

  logic [31:0] seed_r,      seed_nxt;
  logic [31:0] lane_one_r,  lane_one_nxt;
  logic [31:0] lane_two_r,  lane_two_nxt;
  logic        parity_r,    parity_nxt;
  logic [31:0] k_r,         k_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r,  out_hash_nxt;

  logic [31:0] word_r;
  logic [2:0]  nvalid_r;
  logic [31:0] klen_r;
  logic        first_r;
  logic        last_r;

  logic [31:0] mul_op;
  logic [31:0] prod;
  logic [31:0] mul_res;
  logic        out_free;
  logic        en;

  assign en       = ctrl.step_en;
  assign out_free = !out_valid_r || out_ready;

  // status toward the sequencer
  always_comb begin
    stat.full     = (nvalid_r >= NV_FULL);
    stat.partial  = (nvalid_r != 3'd0) && (nvalid_r < NV_FULL);
    stat.last     = last_r;
    stat.out_free = out_free;
  end

  // multiplier operand select
  always_comb begin
    case (ctrl.word.src)
      SRC_WORD:  mul_op = word_r;
      SRC_KMIX:  mul_op = k_r ^ (k_r >> ctrl.word.shamt);
      SRC_LANE:  mul_op = parity_r ? lane_two_r : lane_one_r;
      SRC_TAIL:  mul_op = lane_two_r ^ (word_r & tail_mask(nvalid_r));
      SRC_FIN_A: mul_op = lane_one_r ^ (lane_two_r >> ctrl.word.shamt);
      SRC_FIN_B: mul_op = lane_two_r ^ (lane_one_r >> ctrl.word.shamt);
      default:   mul_op = word_r;
    endcase
  end

  // shared multiplier, low 32 bits of the product
  assign prod    = mul_op * MIX_MUL;
  assign mul_res = ctrl.word.xor_k ? (prod ^ k_r) : prod;

  // register updates driven by the control word
  always_comb begin
    seed_nxt      = cfg_wr ? cfg_seed : seed_r;
    lane_one_nxt  = lane_one_r;
    lane_two_nxt  = lane_two_r;
    parity_nxt    = parity_r;
    k_nxt         = k_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (en) begin
      // open a new key
      if (ctrl.word.init && first_r) begin
        lane_one_nxt = seed_r ^ klen_r;
        lane_two_nxt = 32'd0;
        parity_nxt   = 1'b0;
      end

      // product writeback
      case (ctrl.word.dst)
        DST_K: k_nxt = mul_res;
        DST_A: lane_one_nxt = mul_res;
        DST_B: lane_two_nxt = mul_res;
        DST_LANE: begin
          if (parity_r) begin
            lane_two_nxt = mul_res;
          end else begin
            lane_one_nxt = mul_res;
          end
        end
        default: ;
      endcase

      if (ctrl.word.flip) begin
        parity_nxt = !parity_r;
      end

      // hand the hash over and clear the lanes
      if (ctrl.word.emit) begin
        out_hash_nxt  = {lane_one_r, lane_two_r};
        out_valid_nxt = 1'b1;
        lane_one_nxt  = 32'd0;
        lane_two_nxt  = 32'd0;
        parity_nxt    = 1'b0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      lane_one_r  <= 32'd0;
      lane_two_r  <= 32'd0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      lane_one_r  <= lane_one_nxt;
      lane_two_r  <= lane_two_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
    if (load) begin
      word_r   <= in_data_word;
      nvalid_r <= in_valid_bytes;
      klen_r   <= in_key_length;
      first_r  <= in_first_word;
      last_r   <= in_last_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // checks
  `MMH_ASSERT(a_emit_clears, clk, rst_n, (en && ctrl.word.emit) |=>
    (lane_one_r == 32'd0 && lane_two_r == 32'd0 && !parity_r),
    "lanes not cleared after emit")
  `MMH_ASSERT(a_valid_source, clk, rst_n, $rose(out_valid_r) |->
    ($past(ctrl.word.emit) && $past(en)),
    "result raised outside the emit step")
  `MMH_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && !out_ready) |=>
    (out_valid_r && $stable(out_hash_r)),
    "result dropped or changed while stalled")

endmodule

`default_nettype wire

// ===== design/murmur_hash_64b.sv =====
// A key word is taken only at the idle step; the next one waits until the program
//   is back there. A full word runs the mix, mix-shift and lane steps, a partial
//   word the mix and tail steps, an empty one the mix step; all share the 32-bit
//   multiplier. A last item adds four finalization rounds and the output load.
// Reset: synchronous active low; lanes cleared, seed set to 0xABC84D09.
// ----------------------------------------------------------------------------
// murmur_hash_64b
// MurmurHash2 64B over little-endian 32-bit key words, microcoded control.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_hash_64b
  import mmh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_seed,
  // key words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic [31:0] in_key_length,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  // hash result
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_hash_value
);

  dp_stat_t stat;
  dp_ctrl_t ctrl;

  // seed register is always writable
  assign cfg_ready = 1'b1;

  // control sequencer
  mmh_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath
  mmh_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_seed       (cfg_seed),
    .load           (in_valid && in_ready),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_key_length  (in_key_length),
    .in_first_word  (in_first_word),
    .in_last_word   (in_last_word),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire
